>>> design/cbsw_pkg.sv
// Package for the class-balanced sample weight block.
// Holds the weight mode codes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package cbsw_pkg;

  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_LINEAR = 3'd1;
  localparam logic [2:0] MODE_QUAD   = 3'd2;
  localparam logic [2:0] MODE_CUBIC  = 3'd3;
  localparam logic [2:0] MODE_EXP    = 3'd4;

  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam int MAG_W = 48;
  localparam int SUM_W = 56;

  // truncating integer square root
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x, r, b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != '0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q28 value of 10^(2^k/256): repeated truncating square roots of 10
  function automatic logic [31:0] root_q28(input int k);
    logic [63:0] r;
    r = isqrt64(64'd10 << 56);
    for (int j = 7; j > k; j--) r = isqrt64(r << 28);
    return r[31:0];
  endfunction

  // Q28 roots 10^(2^k/256), k = 0..7
  localparam logic [31:0] ROOT_Q28 [8] = '{
    root_q28(0), root_q28(1), root_q28(2), root_q28(3),
    root_q28(4), root_q28(5), root_q28(6), root_q28(7)
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_EXP, ST_EXPSC, ST_EXPDIV, ST_STORE,
    ST_RDADDR, ST_RDDATA, ST_DIV, ST_OUT
  } state_t;

endpackage

>>> design/cbsw_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Uses no package items.
`timescale 1ns / 1ps
module cbsw_divider #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // shift in the next numerator bit and test subtract
  always_comb begin
    trial = {rem[DEN_W-1:0], num[NUM_W-1]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= numer;
        den  <= denom;
        rem  <= '0;
        quot <= '0;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        if (!diff[DEN_W]) begin
          rem  <= diff;
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> design/class_balanced_sample_weights.sv
// Class-balanced sample weights: top level with sequencer and sample store.
// Depends on cbsw_pkg and cbsw_divider.
//
// Usage: samples enter on the input channel (in_valid / in_stall); each
// transaction carries drug_response, is_sensitive and last_sample. A sample
// is stored with its magnitude and the block stalls until it is back in
// idle; cubic mode adds a second multiply step, exponential mode a root
// step per fraction bit and a scaling step, and a negative exponent a wait
// on the shared divider. After the sample marked last_sample, one weight
// per stored sample is sent in load order on the output channel
// (out_valid / out_stall); each weight passes the read-address, read-data
// and divide states, its time set by the 72-bit bit-serial divider (one
// quotient bit per cycle). A stalled output holds its payload and adds the
// stall length; the input is ready again once the read-address state
// returns to idle after the final weight is taken. Samples beyond
// MAX_SAMPLES are dropped and flagged on every weight of the run.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready
// and should only be written while idle.
// Reset (rst, synchronous) sets weight_mode to linear, threshold to zero,
// and clears the sums, count and flags; the store is not cleared.
`timescale 1ns / 1ps
module class_balanced_sample_weights #(
  parameter int MAX_SAMPLES   = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] drug_response,
  input  logic               is_sensitive,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        sample_weight,
  output logic [5:0]         sample_index,
  output logic               last_weight,
  output logic               samples_dropped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam int MAG_W = cbsw_pkg::MAG_W;
  localparam int SUM_W = cbsw_pkg::SUM_W;
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int NUM_W = 72;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  cbsw_pkg::state_t state, state_next;

  logic [2:0]         weight_mode;
  logic signed [15:0] threshold;
  logic [SUM_W-1:0]   sens_sum, res_sum;
  logic [CW-1:0]      count;
  logic               overflow;
  logic [CW-1:0]      emit_idx;
  logic               lab_in, last_in;
  logic signed [16:0] dval;
  logic [16:0]        ad;
  logic [2:0]         step;
  logic [33:0]        acc;
  logic [31:0]        p;
  logic [7:0]         frac;
  logic signed [3:0]  ten_n;
  logic [MAG_W-1:0]   mag;
  logic               run_none;
  logic signed [16:0] dclamp;
  logic [12:0]        dsplit;
  logic [63:0]        exp_prod;

  logic [MAG_W-1:0]   mag_mem [MAX_SAMPLES];
  logic               lab_mem [MAX_SAMPLES];
  logic [MAG_W-1:0]   rd_mag;
  logic               rd_lab;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_q;
  logic [SUM_W-1:0]   div_den;
  logic               div_den_zero;
  logic [16:0]        wt;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != cbsw_pkg::ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= cbsw_pkg::MODE_LINEAR;
      threshold   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == cbsw_pkg::CFG_MODE) weight_mode <= cfg_data[2:0];
      else threshold <= cfg_data;
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (state == cbsw_pkg::ST_STORE && count < CW'(MAX_SAMPLES)) begin
      mag_mem[count[AW-1:0]] <= mag;
      lab_mem[count[AW-1:0]] <= lab_in;
    end
    rd_mag <= mag_mem[emit_idx[AW-1:0]];
    rd_lab <= lab_mem[emit_idx[AW-1:0]];
  end

  cbsw_divider #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num),
    .denom(div_den), .done(div_done), .quot(div_q)
  );

  // shift from a given fraction width to FRACTION_BITS, saturate to 48 bits
  function automatic logic [MAG_W-1:0] rescale_sat(input logic [127:0] v,
                                                   input int from);
    logic [127:0] r;
    begin
      if (FRACTION_BITS >= from) r = v << (FRACTION_BITS - from);
      else r = v >> (from - FRACTION_BITS);
      rescale_sat = (r > 128'(MAG_MAX)) ? MAG_MAX : r[MAG_W-1:0];
    end
  endfunction

  function automatic logic [23:0] pow10(input logic [2:0] n);
    begin
      case (n)
        3'd0: pow10 = 24'd1;
        3'd1: pow10 = 24'd10;
        3'd2: pow10 = 24'd100;
        3'd3: pow10 = 24'd1000;
        3'd4: pow10 = 24'd10000;
        3'd5: pow10 = 24'd100000;
        3'd6: pow10 = 24'd1000000;
        default: pow10 = 24'd1;
      endcase
    end
  endfunction

  // clamp d to +-6.0, split it as n + f/256, and form the next root product
  always_comb begin
    dclamp   = (dval < -17'sd1536) ? -17'sd1536 :
               (dval > 17'sd1536) ? 17'sd1536 : dval;
    dsplit   = 13'(dclamp + 17'sd1536);
    exp_prod = 64'(p) * 64'(cbsw_pkg::ROOT_Q28[step]);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cbsw_pkg::ST_IDLE:   if (in_valid) state_next = cbsw_pkg::ST_MAG;
      cbsw_pkg::ST_MAG: begin
        if (weight_mode == cbsw_pkg::MODE_EXP) state_next = cbsw_pkg::ST_EXP;
        else if (weight_mode == cbsw_pkg::MODE_CUBIC && step == 3'd0)
          state_next = cbsw_pkg::ST_MAG;
        else state_next = cbsw_pkg::ST_STORE;
      end
      cbsw_pkg::ST_EXP:    if (step == 3'd7) state_next = cbsw_pkg::ST_EXPSC;
      cbsw_pkg::ST_EXPSC:
        state_next = ten_n[3] ? cbsw_pkg::ST_EXPDIV : cbsw_pkg::ST_STORE;
      cbsw_pkg::ST_EXPDIV: if (div_done) state_next = cbsw_pkg::ST_STORE;
      cbsw_pkg::ST_STORE:
        if (!last_in) state_next = cbsw_pkg::ST_IDLE;
        else if (count == '0 && !(count < CW'(MAX_SAMPLES)))
          state_next = cbsw_pkg::ST_IDLE;
        else state_next = cbsw_pkg::ST_RDADDR;
      cbsw_pkg::ST_RDADDR:
        state_next = (emit_idx == count) ? cbsw_pkg::ST_IDLE : cbsw_pkg::ST_RDDATA;
      cbsw_pkg::ST_RDDATA: state_next = cbsw_pkg::ST_DIV;
      cbsw_pkg::ST_DIV:    if (div_done) state_next = cbsw_pkg::ST_OUT;
      cbsw_pkg::ST_OUT:    if (!out_stall) state_next = cbsw_pkg::ST_RDADDR;
      default:             state_next = cbsw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cbsw_pkg::ST_IDLE;
    else state <= state_next;
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == cbsw_pkg::ST_EXPSC && ten_n[3]) begin
      div_start = 1'b1;
      div_num   = NUM_W'({32'(p), FRACTION_BITS'(0)});
      div_den   = SUM_W'(pow10(3'(-ten_n)));
    end else if (state == cbsw_pkg::ST_RDDATA) begin
      div_start = 1'b1;
      div_num   = NUM_W'({rd_mag, 15'd0});
      div_den   = rd_lab ? sens_sum : res_sum;
    end
  end

  // weight from quotient
  always_comb begin
    if (run_none) wt = 17'd65536;
    else if (div_den_zero) wt = '0;
    else if (div_q > NUM_W'(65536)) wt = 17'd65536;
    else wt = div_q[16:0];
  end

  always_ff @(posedge clk) begin
    if (state == cbsw_pkg::ST_RDDATA)
      div_den_zero <= rd_lab ? (sens_sum == '0) : (res_sum == '0);
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      sens_sum  <= '0;
      res_sum   <= '0;
      count     <= '0;
      overflow  <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      case (state)
        cbsw_pkg::ST_IDLE: begin
          step <= '0;
          if (in_valid) begin
            dval    <= 17'(drug_response) - 17'(threshold);
            ad      <= ((17'(drug_response) - 17'(threshold)) < 0)
                       ? 17'(-(17'(drug_response) - 17'(threshold)))
                       : 17'(drug_response) - 17'(threshold);
            lab_in  <= is_sensitive;
            last_in <= last_sample;
          end
        end
        cbsw_pkg::ST_MAG: begin
          case (weight_mode)
            cbsw_pkg::MODE_NONE: mag <= rescale_sat(128'd1, 0);
            cbsw_pkg::MODE_QUAD:
              mag <= rescale_sat(128'(34'(ad) * 34'(ad)), 16);
            cbsw_pkg::MODE_CUBIC: begin
              if (step == 3'd0) begin
                acc  <= 34'(ad) * 34'(ad);
                step <= 3'd1;
              end else mag <= rescale_sat(128'(51'(acc) * 51'(ad)), 24);
            end
            cbsw_pkg::MODE_EXP: begin
              frac  <= dsplit[7:0];
              ten_n <= 4'(dsplit[12:8]) - 4'sd6;
              p     <= 32'd268435456;
              step  <= '0;
            end
            default: mag <= rescale_sat(128'(ad), 8);
          endcase
        end
        cbsw_pkg::ST_EXP: begin
          if (frac[step]) p <= 32'(exp_prod >> 28);
          step <= step + 1'b1;
        end
        cbsw_pkg::ST_EXPSC:
          if (!ten_n[3]) mag <= rescale_sat(128'(64'(p) * 64'(pow10(3'(ten_n)))), 28);
        cbsw_pkg::ST_EXPDIV:
          if (div_done) mag <= rescale_sat(128'(div_q), 28 + FRACTION_BITS)
                               ;
        cbsw_pkg::ST_STORE: begin
          if (count < CW'(MAX_SAMPLES)) begin
            count <= count + 1'b1;
            if (lab_in)
              sens_sum <= (SUM_MAX - sens_sum < SUM_W'(mag)) ? SUM_MAX
                          : sens_sum + SUM_W'(mag);
            else
              res_sum <= (SUM_MAX - res_sum < SUM_W'(mag)) ? SUM_MAX
                         : res_sum + SUM_W'(mag);
          end else overflow <= 1'b1;
          emit_idx <= '0;
          run_none <= (weight_mode == cbsw_pkg::MODE_NONE);
        end
        cbsw_pkg::ST_RDADDR: begin
          if (emit_idx == count) begin
            sens_sum <= '0;
            res_sum  <= '0;
            count    <= '0;
            overflow <= 1'b0;
          end
        end
        cbsw_pkg::ST_DIV:
          if (div_done) begin
            out_valid       <= 1'b1;
            sample_weight   <= wt;
            sample_index    <= 6'(emit_idx);
            last_weight     <= (emit_idx + 1'b1 == count);
            samples_dropped <= overflow;
          end
        cbsw_pkg::ST_OUT:
          if (!out_stall) begin
            out_valid <= 1'b0;
            emit_idx  <= emit_idx + 1'b1;
          end
        default: ;
      endcase
    end
  end
endmodule

>>> dv/cbsw_checker.sv
// Scoreboard for the class-balanced sample weight block: models the sample
// store and class sums, predicts each weight and compares. Depends on cbsw_pkg.
`timescale 1ns / 1ps
module cbsw_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] drug_response,
  input  logic               is_sensitive,
  input  logic               last_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [16:0]        sample_weight,
  input  logic [5:0]         sample_index,
  input  logic               last_weight,
  input  logic               samples_dropped,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 weights_owed
);

  localparam int          CAPACITY = 64;
  localparam logic [63:0] MAG_MAX  = (64'd1 << cbsw_pkg::MAG_W) - 64'd1;
  localparam logic [63:0] SUM_MAX  = (64'd1 << cbsw_pkg::SUM_W) - 64'd1;

  typedef struct packed {
    logic [16:0] weight;
    logic [5:0]  index;
    logic        last;
    logic        dropped;
  } weight_t;

  weight_t     weight_q[$];
  logic [2:0]  mode_r;
  logic signed [15:0] thr_r;
  logic [47:0] mag_mem [CAPACITY];
  logic        sens_mem [CAPACITY];
  logic [63:0] sens_sum, res_sum;
  int          loaded;
  logic        overflowed;
  logic [63:0] root_tab [8];

  assign weights_owed = weight_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] ten_pow(int n);
    logic [63:0] v;
    v = 1;
    repeat (n) v = v * 10;
    return v;
  endfunction

  // 10^d for Q8.8 d, clamped to +-6.0, result with 24 fraction bits
  function automatic logic [63:0] exp_ten(longint d);
    logic [63:0] p, u;
    int          n;
    p = 64'd1 << 28;
    if (d < -1536) d = -1536;
    if (d > 1536) d = 1536;
    u = 64'(d + 1536);
    n = int'(u >> 8) - 6;
    for (int k = 0; k < 8; k++)
      if (u[k]) p = (p * root_tab[k]) >> 28;
    if (n >= 0) return (p * ten_pow(n)) >> 4;
    return ((p << 24) / ten_pow(-n)) >> 28;
  endfunction

  function automatic logic [47:0] sample_magnitude(logic signed [15:0] resp);
    longint      d;
    logic [63:0] ad, v;
    d  = longint'(resp) - longint'(thr_r);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    case (mode_r)
      cbsw_pkg::MODE_NONE:  v = 64'd1 << 24;
      cbsw_pkg::MODE_QUAD:  v = (ad * ad) << 8;
      cbsw_pkg::MODE_CUBIC: v = ad * ad * ad;
      cbsw_pkg::MODE_EXP:   v = exp_ten(d);
      default:              v = ad << 16;
    endcase
    return (v > MAG_MAX) ? MAG_MAX[47:0] : v[47:0];
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] s, logic [47:0] m);
    return (SUM_MAX - s < 64'(m)) ? SUM_MAX : s + 64'(m);
  endfunction

  initial begin
    root_tab[7] = int_sqrt(64'd10 << 56);
    for (int k = 7; k > 0; k--) root_tab[k-1] = int_sqrt(root_tab[k] << 28);
  end

  always @(posedge clk) begin
    weight_t     w, got;
    logic [63:0] s, q;
    logic [47:0] m;
    if (rst) begin
      mode_r     = cbsw_pkg::MODE_LINEAR;
      thr_r      = '0;
      sens_sum   = 0;
      res_sum    = 0;
      loaded     = 0;
      overflowed = 1'b0;
      fail_count = 0;
      weight_q.delete();
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cbsw_pkg::CFG_MODE) mode_r = cfg_data[2:0];
        else thr_r = cfg_data;
      end
      // store sample, emit the run's weights on the last one
      if (in_valid && !in_stall) begin
        if (loaded < CAPACITY) begin
          m = sample_magnitude(drug_response);
          mag_mem[loaded]  = m;
          sens_mem[loaded] = is_sensitive;
          if (is_sensitive) sens_sum = sat_add(sens_sum, m);
          else res_sum = sat_add(res_sum, m);
          loaded++;
        end else begin
          overflowed = 1'b1;
        end
        if (last_sample) begin
          for (int i = 0; i < loaded; i++) begin
            if (mode_r == cbsw_pkg::MODE_NONE) begin
              q = 65536;
            end else begin
              s = sens_mem[i] ? sens_sum : res_sum;
              q = (s == 0) ? 0 : (64'(mag_mem[i]) << 15) / s;
              if (q > 65536) q = 65536;
            end
            w.weight  = q[16:0];
            w.index   = 6'(i);
            w.last    = (i + 1 == loaded);
            w.dropped = overflowed;
            weight_q.push_back(w);
          end
          sens_sum   = 0;
          res_sum    = 0;
          loaded     = 0;
          overflowed = 1'b0;
        end
      end
      // compare each output transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{sample_weight, sample_index, last_weight, samples_dropped};
        if (weight_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected weight transaction %p", $realtime, got);
          fail_count++;
        end else begin
          w = weight_q.pop_front();
          if (got !== w) begin
            if (fail_count < 10)
              $display("%0t: weight mismatch: expected %p, got %p", $realtime, w, got);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> dv/tb_class_balanced_sample_weights.sv
// Testbench top for class_balanced_sample_weights: drives samples, register
// writes and output stalls; checking lives in cbsw_checker. Depends on cbsw_pkg.
`timescale 1ns / 1ps
module tb_class_balanced_sample_weights;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 200;

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic signed [15:0] drug_response;
  logic               is_sensitive, last_sample;
  logic               out_valid, out_stall;
  logic [16:0]        sample_weight;
  logic [5:0]         sample_index;
  logic               last_weight, samples_dropped;
  logic               cfg_valid, cfg_ready, cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count, weights_owed;
  int                 idle_cycles, stall_left, samples_sent;
  bit                 no_gaps;
  logic signed [15:0] thr_now;

  class_balanced_sample_weights i_dut (.*);

  cbsw_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold off the output channel in random bursts
  always @(negedge clk) begin
    if (rst || no_gaps) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap();
    end
    out_stall = (stall_left != 0);
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_class_balanced_sample_weights: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(logic signed [15:0] resp, logic sens, logic last);
    int g;
    @(negedge clk);
    in_valid      = 1'b1;
    drug_response = resp;
    is_sensitive  = sens;
    last_sample   = last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // wait for every weight of the run, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (weights_owed == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == cbsw_pkg::CFG_THRESHOLD) thr_now = val;
  endtask

  // random response: half anywhere, half near the threshold
  function automatic logic [15:0] pick_response();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'(int'(thr_now) + $urandom_range(0, 3200) - 1600);
  endfunction

  task automatic send_run(int len);
    for (int i = 0; i < len; i++)
      send_sample(pick_response(), 1'($urandom), i == len - 1);
    drain();
  endtask

  initial begin
    int  len;
    bit  overflow_done;
    rst           = 1'b1;
    in_valid      = 1'b0;
    drug_response = '0;
    is_sensitive  = 1'b0;
    last_sample   = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = cbsw_pkg::CFG_MODE;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    thr_now       = '0;
    samples_sent  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // linear at reset settings: response extremes, both labels
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh0100, 1'b1, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b1);
    drain();
    // threshold extremes with a zero class sum on each side in turn
    write_reg(cbsw_pkg::CFG_THRESHOLD, 16'h8000);
    send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b1);
    drain();
    write_reg(cbsw_pkg::CFG_THRESHOLD, 16'h7fff);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh7fff, 1'b0, 1'b1);
    drain();
    // every mode, unknown codes included
    write_reg(cbsw_pkg::CFG_THRESHOLD, 16'h0000);
    for (int md = 0; md < 8; md++) begin
      write_reg(cbsw_pkg::CFG_MODE, 16'(md));
      send_sample(16'shfa00, 1'b1, 1'b0);
      send_sample(16'sh0680, 1'b1, 1'b0);
      send_sample(16'sh0033, 1'b0, 1'b1);
      drain();
    end

    // random runs with occasional reconfiguration; one run fills the store
    // and drops its final sample
    overflow_done = 0;
    while (samples_sent < 130) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0)
        write_reg(cbsw_pkg::CFG_MODE, 16'($urandom_range(0, 7)));
      if ($urandom_range(0, 2) == 0)
        write_reg(cbsw_pkg::CFG_THRESHOLD, 16'($urandom));
      if (!overflow_done && samples_sent > 50) begin
        len = 65;
        overflow_done = 1;
      end else begin
        len = $urandom_range(1, 8);
      end
      send_run(len);
    end

    no_gaps = 1'b0;
    drain();
    if (fail_count == 0 && weights_owed == 0) begin
      $display("tb_class_balanced_sample_weights: PASS");
    end else begin
      $display("tb_class_balanced_sample_weights: FAIL");
    end
    $finish;
  end

endmodule
